// ----- hdl/vertex_rotate_translate_project_unit_assert.svh -----
// assertion macros used by the vertex projection queue
`ifndef VERTEX_ROTATE_TRANSLATE_PROJECT_UNIT_ASSERT_SVH
`define VERTEX_ROTATE_TRANSLATE_PROJECT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VRTP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VRTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/vrtp_pkg.sv -----
// ----------------------------------------------------------------------------
// vrtp_pkg
// shared types and constants of the vertex projection unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vrtp_pkg;

   // csr register indexes
   localparam logic [2:0] CSR_COS_ANGLE     = 3'd0;
   localparam logic [2:0] CSR_SIN_ANGLE     = 3'd1;
   localparam logic [2:0] CSR_Z_OFFSET      = 3'd2;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_SCREEN_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_SPLAT_OFFSET  = 3'd5;

   // reset values
   localparam logic signed [15:0] RST_COS_ANGLE     = 16'sd16384;
   localparam logic signed [15:0] RST_SIN_ANGLE     = 16'sd0;
   localparam logic signed [15:0] RST_Z_OFFSET      = 16'sd4096;
   localparam logic [11:0]        RST_SCREEN_WIDTH  = 12'd960;
   localparam logic [11:0]        RST_SCREEN_HEIGHT = 12'd960;
   localparam logic [7:0]         RST_SPLAT_OFFSET  = 8'd5;

   // fixed-point formats
   localparam int TRIG_FRAC = 14;
   localparam int ZOFF_FRAC = 12;

   // quotient magnitude bits kept by the divider
   localparam int QUOT_BITS = 17;

   // 16 bit saturation limits
   localparam logic signed [15:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAT_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [15:0] cos_angle;
      logic signed [15:0] sin_angle;
      logic signed [15:0] z_offset;
      logic [11:0]        screen_width;
      logic [11:0]        screen_height;
      logic [7:0]         splat_offset;
   } cfg_type;

   // depth classification of one vertex
   typedef struct packed {
      logic z_zero;
      logic z_nonpos;
   } flag_type;

   // width of the rotated and translated depth for a coordinate format
   function automatic int zr_width(int frac_bits);
      int ztw;
      ztw = 16 + frac_bits + TRIG_FRAC - ZOFF_FRAC;
      return ((ztw > 32) ? ztw : 32) + 2;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/vrtp_req_if.sv -----
// ----------------------------------------------------------------------------
// vrtp_req_if
// vertex request channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vrtp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vert_x;
   logic signed [15:0] vert_y;
   logic signed [15:0] vert_z;
   logic               op;

   modport source (output valid, vert_x, vert_y, vert_z, op, input ready);
   modport sink (input valid, vert_x, vert_y, vert_z, op, output ready);
endinterface
`default_nettype wire

// ----- hdl/vrtp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vrtp_rsp_if
// projected pixel response channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface vrtp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic               on_screen;
   logic               behind_viewer;

   modport source (output valid, screen_x, screen_y, on_screen, behind_viewer,
                   input ready);
   modport sink (input valid, screen_x, screen_y, on_screen, behind_viewer,
                 output ready);
endinterface
`default_nettype wire

// ----- hdl/vrtp_front.sv -----
// ----------------------------------------------------------------------------
// vrtp_front
// accepts vertices, rotates, translates and builds projection numerators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrtp_front #(
   parameter int FRAC_BITS = 14
) (
   input  wire                  clock,
   input  wire                  reset,
   vrtp_req_if.sink             req_bus,
   input  vrtp_pkg::cfg_type    cfg,
   output logic                 out_valid,
   input  wire                  out_ready,
   output logic signed [vrtp_pkg::zr_width(FRAC_BITS)+14:0] out_nx,
   output logic signed [vrtp_pkg::zr_width(FRAC_BITS)+14:0] out_ny,
   output logic signed [vrtp_pkg::zr_width(FRAC_BITS):0]    out_den,
   output vrtp_pkg::flag_type   out_flags
);
   import vrtp_pkg::*;

   localparam int ZSH = FRAC_BITS + TRIG_FRAC - ZOFF_FRAC;
   localparam int ZTW = 16 + ZSH;
   localparam int ZW  = ((ZTW > 32) ? ZTW : 32) + 2;
   localparam int SW  = ZW + 1;
   localparam int DW  = ZW + 1;
   localparam int NW  = SW + 14;
   localparam int YW  = 16 + TRIG_FRAC;

   logic [3:0] v_ff;
   logic       adv;

   logic signed [31:0]    p_xc_ff, p_zs_ff, p_xs_ff, p_zc_ff;
   logic signed [31:0]    p_xc_in, p_zs_in, p_xs_in, p_zc_in;
   logic signed [ZTW-1:0] zot_ff;
   logic signed [YW-1:0]  yr1_ff, yr2_ff;
   logic                  op1_ff, op2_ff, op3_ff;

   logic signed [ZW-1:0]  xr_ff, zr_ff, xr_in, zr_in;
   logic signed [SW-1:0]  a_ff, b_ff, a_in, b_in;
   logic signed [DW-1:0]  den3_ff, den3_in, den4_ff;
   flag_type              fl3_ff, fl3_in, fl4_ff;

   logic signed [12:0]      wq, hq;
   logic signed [8:0]       offq;
   logic signed [SW+12:0]   mx, my;
   logic signed [DW+8:0]    mo;
   logic signed [NW-1:0]    nx_ff, ny_ff, nx_in, ny_in;

   // pipeline moves when the last stage is empty or drains
   assign adv           = !v_ff[3] || out_ready;
   assign req_bus.ready = adv;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], req_bus.valid};
      end
   end

   // stage 1: rotation products
   assign p_xc_in = req_bus.vert_x * cfg.cos_angle;
   assign p_zs_in = req_bus.vert_z * cfg.sin_angle;
   assign p_xs_in = req_bus.vert_x * cfg.sin_angle;
   assign p_zc_in = req_bus.vert_z * cfg.cos_angle;

   always_ff @(posedge clock) begin
      if (adv) begin
         p_xc_ff <= p_xc_in;
         p_zs_ff <= p_zs_in;
         p_xs_ff <= p_xs_in;
         p_zc_ff <= p_zc_in;
         zot_ff  <= $signed({cfg.z_offset, {ZSH{1'b0}}});
         yr1_ff  <= $signed({req_bus.vert_y, {TRIG_FRAC{1'b0}}});
         op1_ff  <= req_bus.op;
      end
   end

   // stage 2: rotated x and translated z
   assign xr_in = ZW'(p_xc_ff) - ZW'(p_zs_ff);
   assign zr_in = ZW'(p_xs_ff) + ZW'(p_zc_ff) + ZW'(zot_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         xr_ff  <= xr_in;
         zr_ff  <= zr_in;
         yr2_ff <= yr1_ff;
         op2_ff <= op1_ff;
      end
   end

   // stage 3: screen-space sums, denominator and depth flags
   assign a_in            = SW'(xr_ff) + SW'(zr_ff);
   assign b_in            = SW'(zr_ff) - SW'(yr2_ff);
   assign den3_in         = $signed({zr_ff, 1'b0});
   assign fl3_in.z_zero   = (zr_ff == '0);
   assign fl3_in.z_nonpos = zr_ff[ZW-1] || (zr_ff == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         den3_ff <= den3_in;
         fl3_ff  <= fl3_in;
         op3_ff  <= op2_ff;
      end
   end

   // stage 4: numerators scaled to pixels, splat offset removed when op is set
   assign wq    = $signed({1'b0, cfg.screen_width});
   assign hq    = $signed({1'b0, cfg.screen_height});
   assign offq  = op3_ff ? $signed({1'b0, cfg.splat_offset}) : 9'sd0;
   assign mx    = a_ff * wq;
   assign my    = b_ff * hq;
   assign mo    = den3_ff * offq;
   assign nx_in = NW'(mx) - NW'(mo);
   assign ny_in = NW'(my) - NW'(mo);

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         den4_ff <= den3_ff;
         fl4_ff  <= fl3_ff;
      end
   end

   assign out_valid = v_ff[3];
   assign out_nx    = nx_ff;
   assign out_ny    = ny_ff;
   assign out_den   = den4_ff;
   assign out_flags = fl4_ff;

endmodule
`default_nettype wire

// ----- hdl/vrtp_queue.sv -----
// ----------------------------------------------------------------------------
// vrtp_queue
// small fifo between the front and the divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrtp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  wire  [WIDTH-1:0]  push_data,
   output logic              pop_valid,
   input  wire               pop_ready,
   output logic [WIDTH-1:0]  pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`include "vertex_rotate_translate_project_unit_assert.svh"
   `VRTP_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "fifo overfilled")
   `VRTP_ASSERT_NEXT(a_fill_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "fill level lost a push")
   `VRTP_ASSERT_NEXT(a_fill_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1, "fill level lost a pop")
   `VRTP_ASSERT_NOW(a_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointers disagree when empty")

endmodule
`default_nettype wire

// ----- hdl/vrtp_back.sv -----
// ----------------------------------------------------------------------------
// vrtp_back
// pipelined restoring divider, saturation and screen bounds check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vrtp_back #(
   parameter int FRAC_BITS = 14
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire  signed [vrtp_pkg::zr_width(FRAC_BITS)+14:0] in_nx,
   input  wire  signed [vrtp_pkg::zr_width(FRAC_BITS)+14:0] in_ny,
   input  wire  signed [vrtp_pkg::zr_width(FRAC_BITS):0]    in_den,
   input  vrtp_pkg::flag_type   in_flags,
   input  vrtp_pkg::cfg_type    cfg,
   vrtp_rsp_if.source           rsp_bus
);
   import vrtp_pkg::*;

   localparam int ZSH = FRAC_BITS + TRIG_FRAC - ZOFF_FRAC;
   localparam int ZTW = 16 + ZSH;
   localparam int ZW  = ((ZTW > 32) ? ZTW : 32) + 2;
   localparam int SW  = ZW + 1;
   localparam int DW  = ZW + 1;
   localparam int NW  = SW + 14;
   localparam int QB  = QUOT_BITS;
   localparam int CW  = DW + QB + 1;

   logic              adv;
   logic [QB+1:0]     v_ff;

   logic [NW-1:0]     rx_ff [0:QB];
   logic [NW-1:0]     ry_ff [0:QB];
   logic [DW-1:0]     dm_ff [0:QB];
   logic [QB-1:0]     qx_ff [0:QB];
   logic [QB-1:0]     qy_ff [0:QB];
   logic              ngx_ff [0:QB];
   logic              ngy_ff [0:QB];
   logic              ovx_ff [0:QB];
   logic              ovy_ff [0:QB];
   flag_type          fl_ff [0:QB];

   logic              ngx_in, ngy_in;
   logic [NW-1:0]     mx_in, my_in;
   logic [DW-1:0]     dm_in;

   logic signed [15:0] sx_in, sy_in, sx_ff, sy_ff;
   logic               on_in, on_ff, bh_ff;
   logic               insx, insy;

   // whole back pipeline steps when the output register can take a beat
   assign adv      = !v_ff[QB+1] || rsp_bus.ready;
   assign in_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[QB:0], in_valid};
      end
   end

   // entry: sign-normalize to a positive denominator, take magnitudes
   assign ngx_in = (in_nx != '0) && (in_nx[NW-1] != in_den[DW-1]);
   assign ngy_in = (in_ny != '0) && (in_ny[NW-1] != in_den[DW-1]);
   assign mx_in  = in_nx[NW-1] ? NW'(-in_nx) : NW'(in_nx);
   assign my_in  = in_ny[NW-1] ? NW'(-in_ny) : NW'(in_ny);
   assign dm_in  = in_den[DW-1] ? DW'(-in_den) : DW'(in_den);

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0]  <= mx_in;
         ry_ff[0]  <= my_in;
         dm_ff[0]  <= dm_in;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         ngx_ff[0] <= ngx_in;
         ngy_ff[0] <= ngy_in;
         ovx_ff[0] <= 1'b0;
         ovy_ff[0] <= 1'b0;
         fl_ff[0]  <= in_flags;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int SH = QB - 1 - k;
      logic [CW-1:0] trial, top;
      logic          gex, gey, ovx_in, ovy_in;
      logic [NW-1:0] rx_in, ry_in;

      assign trial  = CW'(dm_ff[k]) << SH;
      assign top    = CW'(dm_ff[k]) << QB;
      assign gex    = CW'(rx_ff[k]) >= trial;
      assign gey    = CW'(ry_ff[k]) >= trial;
      assign ovx_in = (k == 0) ? (CW'(rx_ff[k]) >= top) : ovx_ff[k];
      assign ovy_in = (k == 0) ? (CW'(ry_ff[k]) >= top) : ovy_ff[k];
      assign rx_in  = gex ? rx_ff[k] - trial[NW-1:0] : rx_ff[k];
      assign ry_in  = gey ? ry_ff[k] - trial[NW-1:0] : ry_ff[k];

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[k+1]  <= rx_in;
            ry_ff[k+1]  <= ry_in;
            dm_ff[k+1]  <= dm_ff[k];
            qx_ff[k+1]  <= {qx_ff[k][QB-2:0], gex};
            qy_ff[k+1]  <= {qy_ff[k][QB-2:0], gey};
            ngx_ff[k+1] <= ngx_ff[k];
            ngy_ff[k+1] <= ngy_ff[k];
            ovx_ff[k+1] <= ovx_in;
            ovy_ff[k+1] <= ovy_in;
            fl_ff[k+1]  <= fl_ff[k];
         end
      end
   end

   // saturate, bounds check and zero-depth override
   always_comb begin
      if (ngx_ff[QB]) begin
         sx_in = (ovx_ff[QB] || qx_ff[QB][QB-1] ||
                  (qx_ff[QB][15] && qx_ff[QB][14:0] != '0))
               ? SAT_MIN : $signed(16'(-qx_ff[QB][15:0]));
      end else begin
         sx_in = (ovx_ff[QB] || qx_ff[QB][QB-1] || qx_ff[QB][15])
               ? SAT_MAX : $signed(qx_ff[QB][15:0]);
      end
      if (ngy_ff[QB]) begin
         sy_in = (ovy_ff[QB] || qy_ff[QB][QB-1] ||
                  (qy_ff[QB][15] && qy_ff[QB][14:0] != '0))
               ? SAT_MIN : $signed(16'(-qy_ff[QB][15:0]));
      end else begin
         sy_in = (ovy_ff[QB] || qy_ff[QB][QB-1] || qy_ff[QB][15])
               ? SAT_MAX : $signed(qy_ff[QB][15:0]);
      end
      insx  = !ngx_ff[QB] && !ovx_ff[QB] && (qx_ff[QB] < QB'(cfg.screen_width));
      insy  = !ngy_ff[QB] && !ovy_ff[QB] && (qy_ff[QB] < QB'(cfg.screen_height));
      on_in = insx && insy;
      if (fl_ff[QB].z_zero) begin
         sx_in = '0;
         sy_in = '0;
         on_in = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         on_ff <= on_in;
         bh_ff <= fl_ff[QB].z_nonpos;
      end
   end

   assign rsp_bus.valid         = v_ff[QB+1];
   assign rsp_bus.screen_x      = sx_ff;
   assign rsp_bus.screen_y      = sy_ff;
   assign rsp_bus.on_screen     = on_ff;
   assign rsp_bus.behind_viewer = bh_ff;

endmodule
`default_nettype wire

// ----- hdl/vertex_rotate_translate_project_unit.sv -----
// Throughput: one vertex per cycle while the response channel is not stalled;
// the 17-stage divider pipeline takes a new quotient every cycle unless stalled,
// and a 4-entry fifo decouples it from the front pipeline.
// Reset: synchronous active high; clears all valid flags and fifo state and
// loads the csr registers with their default values.
// ----------------------------------------------------------------------------
// vertex_rotate_translate_project_unit
// rotates a vertex about y, translates z and projects it to screen pixels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vertex_rotate_translate_project_unit #(
   parameter int FRAC_BITS   = 14,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire        clock,
   input  wire        reset,
   vrtp_req_if.sink   req_bus,
   vrtp_rsp_if.source rsp_bus,
   input  wire        csr_wr_en,
   input  wire [2:0]  csr_index,
   input  wire [15:0] csr_wdata
);
   import vrtp_pkg::*;

   localparam int ZSH = FRAC_BITS + TRIG_FRAC - ZOFF_FRAC;
   localparam int ZTW = 16 + ZSH;
   localparam int ZW  = ((ZTW > 32) ? ZTW : 32) + 2;
   localparam int DW  = ZW + 1;
   localparam int NW  = ZW + 15;
   localparam int IW  = 2 * NW + DW + $bits(flag_type);

   cfg_type cfg_ff;

   logic                 f_valid, f_ready;
   logic signed [NW-1:0] f_nx, f_ny;
   logic signed [DW-1:0] f_den;
   flag_type             f_flags;

   logic                 b_valid, b_ready;
   logic [IW-1:0]        b_item;
   flag_type             b_flags;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_angle     <= RST_COS_ANGLE;
         cfg_ff.sin_angle     <= RST_SIN_ANGLE;
         cfg_ff.z_offset      <= RST_Z_OFFSET;
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.splat_offset  <= RST_SPLAT_OFFSET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COS_ANGLE:     cfg_ff.cos_angle     <= $signed(csr_wdata);
            CSR_SIN_ANGLE:     cfg_ff.sin_angle     <= $signed(csr_wdata);
            CSR_Z_OFFSET:      cfg_ff.z_offset      <= $signed(csr_wdata);
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata[11:0];
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata[11:0];
            CSR_SPLAT_OFFSET:  cfg_ff.splat_offset  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // front: rotate, translate, numerators
   vrtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_nx    (f_nx),
      .out_ny    (f_ny),
      .out_den   (f_den),
      .out_flags (f_flags)
   );

   // decoupling fifo
   vrtp_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_flags, f_den, f_ny, f_nx}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_item)
   );

   assign b_flags = b_item[IW-1 -: $bits(flag_type)];

   // back: divide and map to pixels
   vrtp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b_valid),
      .in_ready (b_ready),
      .in_nx    ($signed(b_item[NW-1:0])),
      .in_ny    ($signed(b_item[2*NW-1:NW])),
      .in_den   ($signed(b_item[2*NW+DW-1:2*NW])),
      .in_flags (b_flags),
      .cfg      (cfg_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule
`default_nettype wire

// ----- sim/vrtp_project_checker.sv -----
// ----------------------------------------------------------------------------
// vrtp_project_checker
// watches the request and response channels, predicts each projected pixel
// from the accepted vertex and the current csr copy, and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vrtp_project_checker
   import vrtp_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   vrtp_req_if         req_bus,
   vrtp_rsp_if         rsp_bus,
   input  wire         csr_wr_en,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic               on_scr;
      logic               behind;
   } pixel_type;

   cfg_type   csr_copy;
   pixel_type pixel_queue[$];

   // truncated quotient, saturated, plus the in-range flag
   function automatic logic signed [15:0] axis_pixel(longint num, longint den,
                                                     longint lim, output bit in_range);
      longint q;
      q = num / den;
      in_range = (num >= 0) && (q < lim);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic pixel_type project_vertex(logic signed [15:0] vx,
                                                logic signed [15:0] vy,
                                                logic signed [15:0] vz,
                                                logic point_mode);
      pixel_type p;
      longint x, y, z, c, s, zo, w, h, off, xr, yr, zr, den, nx, ny;
      bit in_x, in_y;
      x = vx; y = vy; z = vz;
      c = csr_copy.cos_angle;
      s = csr_copy.sin_angle;
      zo = csr_copy.z_offset;
      w = csr_copy.screen_width;
      h = csr_copy.screen_height;
      off = point_mode ? longint'(csr_copy.splat_offset) : 0;
      xr = x * c - z * s;
      yr = y * (64'sd1 <<< TRIG_FRAC);
      zr = x * s + z * c + zo * (64'sd1 <<< (14 + TRIG_FRAC - ZOFF_FRAC));
      p = '0;
      p.behind = (zr <= 0);
      if (zr != 0) begin
         den = 2 * zr;
         nx = (xr + zr) * w - off * den;
         ny = (zr - yr) * h - off * den;
         if (den < 0) begin
            den = -den; nx = -nx; ny = -ny;
         end
         p.sx = axis_pixel(nx, den, w, in_x);
         p.sy = axis_pixel(ny, den, h, in_y);
         p.on_scr = in_x && in_y;
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = pixel_queue.size();

   // csr shadow, prediction on request beats, compare on response beats
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         csr_copy <= '{RST_COS_ANGLE, RST_SIN_ANGLE, RST_Z_OFFSET,
                       RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT, RST_SPLAT_OFFSET};
         pixel_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COS_ANGLE:     csr_copy.cos_angle     <= csr_wdata;
               CSR_SIN_ANGLE:     csr_copy.sin_angle     <= csr_wdata;
               CSR_Z_OFFSET:      csr_copy.z_offset      <= csr_wdata;
               CSR_SCREEN_WIDTH:  csr_copy.screen_width  <= csr_wdata[11:0];
               CSR_SCREEN_HEIGHT: csr_copy.screen_height <= csr_wdata[11:0];
               CSR_SPLAT_OFFSET:  csr_copy.splat_offset  <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            pixel_queue.push_back(project_vertex(req_bus.vert_x, req_bus.vert_y,
                                                 req_bus.vert_z, req_bus.op));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_bus.screen_x !== want.sx)
                  report_mismatch("screen_x", rsp_bus.screen_x, want.sx);
               if (rsp_bus.screen_y !== want.sy)
                  report_mismatch("screen_y", rsp_bus.screen_y, want.sy);
               if (rsp_bus.on_screen !== want.on_scr)
                  report_mismatch("on_screen", rsp_bus.on_screen, want.on_scr);
               if (rsp_bus.behind_viewer !== want.behind)
                  report_mismatch("behind_viewer", rsp_bus.behind_viewer, want.behind);
            end
         end
      end
   end

endmodule

// ----- sim/tb_vertex_rotate_translate_project_unit.sv -----
// ----------------------------------------------------------------------------
// tb_vertex_rotate_translate_project_unit
// drives directed and random vertices through several csr settings with
// random stalls on both channels in some phases; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_vertex_rotate_translate_project_unit;
   import vrtp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          idle_cycles = 0;

   vrtp_req_if req_bus();
   vrtp_rsp_if rsp_bus();

   vertex_rotate_translate_project_unit u_dut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   vrtp_project_checker u_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #10 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.vert_x = '0;
      req_bus.vert_y = '0;
      req_bus.vert_z = '0;
      req_bus.op = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   // response back-pressure
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog on cycles with no beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_view(logic [15:0] c, logic [15:0] s, logic [15:0] zo,
                            logic [15:0] w, logic [15:0] h, logic [15:0] off);
      write_csr(CSR_COS_ANGLE, c);
      write_csr(CSR_SIN_ANGLE, s);
      write_csr(CSR_Z_OFFSET, zo);
      write_csr(CSR_SCREEN_WIDTH, w);
      write_csr(CSR_SCREEN_HEIGHT, h);
      write_csr(CSR_SPLAT_OFFSET, off);
   endtask

   // one vertex beat, with optional idle cycles ahead of it
   task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                              logic point_mode);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.vert_x <= vx;
      req_bus.vert_y <= vy;
      req_bus.vert_z <= vz;
      req_bus.op <= point_mode;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly near-unit coordinates, sometimes raw full-range
   function automatic logic [15:0] rand_coord();
      if ($urandom_range(3) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   task automatic random_vertices(int count);
      for (int i = 0; i < count; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, both modes, zero and negative depth
      send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_vertex(16'h0000, 16'h0000, 16'h0000, 1'b1);
      send_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      send_vertex(16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_vertex(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
      send_vertex(16'h0000, 16'h0000, 16'hF000, 1'b0);
      send_vertex(16'h0000, 16'h0000, 16'hE000, 1'b1);
      send_vertex(16'h0010, 16'hFFF0, 16'hF001, 1'b0);
      send_vertex(16'h4000, 16'h4000, 16'h0000, 1'b1);
      send_vertex(16'hFFFF, 16'h0001, 16'h0001, 1'b0);
      send_vertex(16'h2000, 16'hE000, 16'h4000, 1'b1);
      drain_results();

      // extreme registers: zero screen size, max offset, negative trig
      load_view(16'hC000, 16'h4000, 16'h8000, 16'h0000, 16'h0FFF, 16'h00FF);
      send_vertex(16'h0000, 16'h0000, 16'h4000, 1'b1);
      send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
      send_vertex(16'h1000, 16'h1000, 16'hC000, 1'b1);
      drain_results();
      load_view(16'h4000, 16'hC000, 16'h7FFF, 16'h0FFF, 16'h0000, 16'h0000);
      send_vertex(16'h0001, 16'h7FFF, 16'h0000, 1'b1);
      send_vertex(16'h8000, 16'h0000, 16'h8000, 1'b0);
      drain_results();

      // random phase: sender idles more lightly than the receiver
      send_idle_pct = 23; recv_idle_pct = 59;
      load_view(16'h2D41, 16'h2D41, 16'h2000, 16'd640, 16'd480, 16'd3);
      random_vertices(500);
      drain_results();

      // roles swapped, random register values across the whole range
      send_idle_pct = 59; recv_idle_pct = 23;
      load_view(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
      random_vertices(250);
      drain_results();
      load_view(16'h4000, 16'h0000, 16'h1000, 16'd960, 16'd960, 16'd5);
      random_vertices(250);
      drain_results();

      // no idling at all
      send_idle_pct = 0; recv_idle_pct = 0;
      load_view(16'h0000, 16'h4000, 16'h0800, 16'd1, 16'd4095, 16'd255);
      random_vertices(275);
      drain_results();
      load_view(16'h3B21, 16'hE783, 16'h3000, 16'd1920, 16'd1080, 16'd7);
      random_vertices(275);
      drain_results();

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
